// ===== hw/rtl/ufbp_pkg.sv =====
`timescale 1ns / 1ps

package ufbp_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned POS_W = $clog2(BLOCK_BYTES);
  localparam int unsigned MAX_PAYLOAD = 476;
  localparam int unsigned LEN_W = 9;
  localparam int unsigned B2LEN_W = 17;

  localparam logic [31:0] MAGIC_HEAD0 = 32'h0A32_4655;
  localparam logic [31:0] MAGIC_HEAD1 = 32'h9E5D_5157;
  localparam logic [31:0] MAGIC_TAIL = 32'h0AB1_6F30;
  localparam logic [31:0] ADDR_NONE = 32'hFFFF_FFFF;

  localparam logic [POS_W-1:0] POS_HEAD0 = POS_W'(3);
  localparam logic [POS_W-1:0] POS_HEAD1 = POS_W'(7);
  localparam logic [POS_W-1:0] POS_ADDRESS = POS_W'(15);
  localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(19);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_BYTES - 1);

  localparam logic [31:0] RST_BOOT2_BASE = 32'h1000_0000;
  localparam logic [B2LEN_W-1:0] RST_BOOT2_LENGTH = B2LEN_W'(256);
  localparam logic [31:0] RST_SLOT_LENGTH = 32'h0010_0000;
  localparam logic [31:0] RST_APP_BASE = 32'h1000_0000;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_FINISH = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_BOOT2_BASE = 2'd0,
    REG_BOOT2_LENGTH = 2'd1,
    REG_SLOT_LENGTH = 2'd2,
    REG_APP_BASE = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NO_BLOCKS = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_BAD_SIZE = 3'd3,
    ST_OUTSIDE = 3'd4
  } status_t;

  typedef struct packed {
    kind_t kind;
    logic ok;
    logic [31:0] addr;
    logic [LEN_W-1:0] size;
  } event_t;

  typedef struct packed {
    kind_t result_kind;
    logic block_ok;
    logic [31:0] target_address;
    logic [LEN_W-1:0] payload_length;
    logic [LEN_W-1:0] copy_from;
    logic [LEN_W-1:0] copy_length;
    logic [31:0] dest_offset;
    status_t status;
    logic [31:0] image_low;
    logic [31:0] image_high;
  } result_t;

endpackage

// ===== hw/rtl/ufbp_fifo.sv =====
`timescale 1ns / 1ps

module ufbp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_wr;
  logic do_rd;

  assign in_ready = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign do_wr = in_valid && in_ready;
  assign do_rd = out_valid && out_ready;
  assign out_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ufbp_front.sv =====
`timescale 1ns / 1ps

module ufbp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            kind,
  input  logic [7:0]      data_byte,
  output logic            ev_valid,
  input  logic            ev_ready,
  output ufbp_pkg::event_t ev
);

  import ufbp_pkg::*;

  logic [POS_W-1:0] byte_position;
  logic [31:0] word_shift;
  logic [31:0] word_shift_next;
  logic head_magic_ok;
  logic [31:0] captured_address;
  logic [31:0] captured_length;
  logic accept;
  logic is_finish;
  logic at_last;

  assign full = !ev_ready;
  assign accept = push && ev_ready;
  assign is_finish = (kind == KIND_FINISH);
  assign at_last = (byte_position == POS_LAST);
  assign word_shift_next = {data_byte, word_shift[31:8]};

  assign ev_valid = accept && (is_finish || at_last);

  always_comb begin
    ev.kind = is_finish ? KIND_FINISH : KIND_BYTE;
    ev.ok = !is_finish && head_magic_ok && (word_shift_next == MAGIC_TAIL)
            && (captured_length != '0) && (captured_length <= 32'(MAX_PAYLOAD));
    ev.addr = captured_address;
    ev.size = captured_length[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      word_shift <= '0;
      head_magic_ok <= 1'b0;
      captured_address <= '0;
      captured_length <= '0;
    end else if (accept) begin
      if (is_finish) begin
        byte_position <= '0;
      end else begin
        word_shift <= word_shift_next;
        unique case (byte_position)
          POS_HEAD0: head_magic_ok <= (word_shift_next == MAGIC_HEAD0);
          POS_HEAD1: head_magic_ok <= head_magic_ok && (word_shift_next == MAGIC_HEAD1);
          POS_ADDRESS: captured_address <= word_shift_next;
          POS_LENGTH: captured_length <= word_shift_next;
          default: ;
        endcase
        byte_position <= at_last ? '0 : byte_position + POS_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ufbp_back.sv =====
`timescale 1ns / 1ps

module ufbp_back #(
  parameter int unsigned TALLY_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   ev_valid,
  output logic                   ev_ready,
  input  ufbp_pkg::event_t       ev,
  output logic                   res_valid,
  input  logic                   res_ready,
  output ufbp_pkg::result_t      res,
  output logic [TALLY_BITS-1:0]  res_tally
);

  import ufbp_pkg::*;

  logic [31:0] boot2_base;
  logic [B2LEN_W-1:0] boot2_length;
  logic [31:0] slot_length;
  logic [31:0] app_base;
  logic [31:0] limit;
  logic [31:0] app_top;
  logic [31:0] boot2_top;

  logic [31:0] lowest_address;
  logic [31:0] highest_address;
  logic [TALLY_BITS-1:0] block_tally;

  logic s1_valid;
  kind_t s1_kind;
  logic s1_ok;
  logic [31:0] s1_addr;
  logic [LEN_W-1:0] s1_size;
  logic s1_below;
  logic [31:0] s1_overlap;
  logic [31:0] s1_far_ofs;
  logic [31:0] s1_low;
  logic [31:0] s1_high;
  logic [TALLY_BITS-1:0] s1_tally;

  logic load;
  logic [31:0] block_end;
  logic [31:0] low_next;
  logic [31:0] high_next;
  logic [TALLY_BITS-1:0] tally_next;
  logic [31:0] span;
  logic [31:0] derived;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot2_base <= RST_BOOT2_BASE;
      boot2_length <= RST_BOOT2_LENGTH;
      slot_length <= RST_SLOT_LENGTH;
      app_base <= RST_APP_BASE;
      limit <= RST_SLOT_LENGTH + 32'(RST_BOOT2_LENGTH);
      app_top <= RST_APP_BASE + RST_SLOT_LENGTH;
      boot2_top <= RST_BOOT2_BASE + 32'(RST_BOOT2_LENGTH);
    end else begin
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_BOOT2_BASE: boot2_base <= cfg_data;
          REG_BOOT2_LENGTH: boot2_length <= cfg_data[B2LEN_W-1:0];
          REG_SLOT_LENGTH: slot_length <= cfg_data;
          REG_APP_BASE: app_base <= cfg_data;
        endcase
      end
      limit <= slot_length + 32'(boot2_length);
      app_top <= app_base + slot_length;
      boot2_top <= boot2_base + 32'(boot2_length);
    end
  end

  assign ev_ready = !s1_valid || res_ready;
  assign load = ev_valid && ev_ready;

  assign block_end = ev.addr + 32'(ev.size);
  assign low_next = (ev.addr < lowest_address) ? ev.addr : lowest_address;
  assign high_next = (block_end > highest_address) ? block_end : highest_address;
  assign tally_next = (block_tally == '1) ? block_tally : block_tally + TALLY_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lowest_address <= ADDR_NONE;
      highest_address <= '0;
      block_tally <= '0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (res_ready) begin
        s1_valid <= 1'b0;
      end
      if (load) begin
        if (ev.kind == KIND_FINISH) begin
          lowest_address <= ADDR_NONE;
          highest_address <= '0;
          block_tally <= '0;
        end else if (ev.ok) begin
          lowest_address <= low_next;
          highest_address <= high_next;
          block_tally <= tally_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_kind <= ev.kind;
      s1_ok <= ev.ok;
      s1_addr <= ev.addr;
      s1_size <= ev.size;
      s1_below <= (ev.addr < boot2_top);
      s1_overlap <= boot2_top - ev.addr;
      s1_far_ofs <= ev.addr - boot2_base;
      if (ev.kind == KIND_BYTE && ev.ok) begin
        s1_low <= low_next;
        s1_high <= high_next;
        s1_tally <= tally_next;
      end else begin
        s1_low <= lowest_address;
        s1_high <= highest_address;
        s1_tally <= block_tally;
      end
    end
  end

  assign span = s1_high - s1_low;
  assign derived = s1_high - boot2_base;
  assign res_valid = s1_valid;
  assign res_tally = s1_tally;

  always_comb begin
    res.result_kind = s1_kind;
    res.block_ok = 1'b0;
    res.target_address = '0;
    res.payload_length = '0;
    res.copy_from = '0;
    res.copy_length = '0;
    res.dest_offset = '0;
    res.status = ST_OK;
    res.image_low = s1_low;
    res.image_high = s1_high;
    if (s1_kind == KIND_FINISH) begin
      priority if (s1_tally == '0 || s1_low == ADDR_NONE || s1_high <= s1_low) begin
        res.status = ST_NO_BLOCKS;
      end else if (span > limit) begin
        res.status = ST_TOO_LARGE;
      end else if (derived == '0 || derived > limit) begin
        res.status = ST_BAD_SIZE;
      end else if (s1_high > app_top) begin
        res.status = ST_OUTSIDE;
      end else begin
        res.status = ST_OK;
      end
    end else begin
      res.target_address = s1_addr;
      if (s1_ok) begin
        res.block_ok = 1'b1;
        res.payload_length = s1_size;
        if (s1_below) begin
          if (s1_overlap < 32'(s1_size)) begin
            res.copy_from = s1_overlap[LEN_W-1:0];
            res.copy_length = s1_size - s1_overlap[LEN_W-1:0];
            res.dest_offset = 32'(boot2_length);
          end
        end else begin
          res.copy_length = s1_size;
          res.dest_offset = s1_far_ofs;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/uf2_block_parser_top.sv =====
`timescale 1ns / 1ps

// UF2 block parser. Push one file byte per cycle (kind 0) or a finish item
// (kind 1); an item is taken whenever full is low, and full stays low unless
// the event queue or the result queue backs up. The 512th byte of a block
// yields one copy descriptor, a finish yields the image verdict and clears
// the lowest/highest/count accumulators; a partial block is dropped on finish.
// Each result passes the event queue, the back register and the result queue:
// the front parser feeds a 4-entry event queue, the back part
// registers each event once and derives the descriptor or verdict from that
// register, and a 2-entry result queue holds finished results for pop.
// Configuration writes must be issued while the block is idle; the limit and
// top addresses derived from them are registered from the written values.
module uf2_block_parser_top #(
  parameter int unsigned TALLY_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic                  kind,
  input  logic [7:0]            data_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic                  result_kind,
  output logic                  block_ok,
  output logic [31:0]           target_address,
  output logic [8:0]            payload_length,
  output logic [8:0]            copy_from,
  output logic [8:0]            copy_length,
  output logic [31:0]           dest_offset,
  output logic [2:0]            status,
  output logic [31:0]           image_low,
  output logic [31:0]           image_high,
  output logic [TALLY_BITS-1:0] valid_blocks
);

  import ufbp_pkg::*;

  localparam int unsigned EV_W = $bits(event_t);
  localparam int unsigned RES_W = $bits(result_t) + TALLY_BITS;

  logic fe_valid;
  logic fe_ready;
  event_t fe_ev;
  logic [EV_W-1:0] fe_bits;

  logic be_valid;
  logic be_ready;
  logic [EV_W-1:0] be_bits;
  event_t be_ev;

  logic res_valid;
  logic res_ready;
  result_t res;
  logic [TALLY_BITS-1:0] res_tally;
  logic [RES_W-1:0] res_bits;

  logic out_valid;
  logic [RES_W-1:0] out_bits;
  result_t out_res;

  ufbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .data_byte (data_byte),
    .ev_valid  (fe_valid),
    .ev_ready  (fe_ready),
    .ev        (fe_ev)
  );

  assign fe_bits = fe_ev;

  ufbp_fifo #(
    .WIDTH (EV_W),
    .DEPTH (4)
  ) u_ev_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_data   (fe_bits),
    .out_valid (be_valid),
    .out_ready (be_ready),
    .out_data  (be_bits)
  );

  assign be_ev = be_bits;

  ufbp_back #(
    .TALLY_BITS (TALLY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev_valid  (be_valid),
    .ev_ready  (be_ready),
    .ev        (be_ev),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .res_tally (res_tally)
  );

  assign res_bits = {res_tally, res};

  ufbp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res_bits),
    .out_valid (out_valid),
    .out_ready (pop),
    .out_data  (out_bits)
  );

  assign empty = !out_valid;
  assign out_res = out_bits[$bits(result_t)-1:0];
  assign valid_blocks = out_bits[RES_W-1:$bits(result_t)];

  assign result_kind = out_res.result_kind;
  assign block_ok = out_res.block_ok;
  assign target_address = out_res.target_address;
  assign payload_length = out_res.payload_length;
  assign copy_from = out_res.copy_from;
  assign copy_length = out_res.copy_length;
  assign dest_offset = out_res.dest_offset;
  assign status = out_res.status;
  assign image_low = out_res.image_low;
  assign image_high = out_res.image_high;

endmodule
